/* hdl/fir_pkg.sv */
// Shared types and constants for the loadable-tap FIR filter.
// No dependencies; used by the interfaces, the tap cell, the controller and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fir_pkg;

   localparam int MAX_TAPS_DEF     = 64;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COEFF_WIDTH_DEF  = 16;
   localparam int TAP_IDX_W        = 6;
   localparam int TAP_CNT_W        = 7;

   typedef enum logic {
      OP_FILTER = 1'b0,
      OP_LOAD   = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // strobes from the controller to the cell row
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

`default_nettype wire

/* hdl/fir_intf.sv */
// Valid/ready channel interfaces for the FIR filter: request beats and response beats.
// Depends on fir_pkg for the tap index width.
`timescale 1ns / 1ps
`default_nettype none

interface fir_req_if
   import fir_pkg::*;
   #(
      parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
      parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF
   ) ();
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic        [TAP_IDX_W-1:0]    tap_index;
   logic signed [COEFF_WIDTH-1:0]  coeff_value;

   modport source (output valid, op, sample_in, tap_index, coeff_value, input ready);
   modport sink   (input valid, op, sample_in, tap_index, coeff_value, output ready);
endinterface

interface fir_rsp_if
   import fir_pkg::*;
   #(
      parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
   ) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           saturated;

   modport source (output valid, sample_out, saturated, input ready);
   modport sink   (input valid, sample_out, saturated, output ready);
endinterface

`default_nettype wire

/* hdl/fir_filter_loadable_taps.sv */
// Direct-form FIR filter with loadable coefficients, one item at a time.
// A load beat (op = 1) writes one Q1.15 coefficient and gives no response; an
// index at or past MAX_TAPS is dropped. A sample beat (op = 0) shifts the sample
// into the delay line and gives one response beat: the sum of the products over
// the active tap count, rounded half up and saturated, with a flag when clipped.
// A sample beat occupies the block while the partial sum ripples one cell per
// cycle down the row of tap cells after the product stage; the response is
// registered once the sum leaves the last cell, and a previous response still
// waiting on rsp ready holds the block until it is taken. A tap count of zero
// acts as one tap, values above MAX_TAPS act as MAX_TAPS; write csr_ only while
// no beat is in flight.
// Depends on fir_pkg, fir_intf, fir_cell and fir_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_loadable_taps
   import fir_pkg::*;
   #(
      parameter int MAX_TAPS     = MAX_TAPS_DEF,
      parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
      parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF
   ) (
      input  wire logic                 clock,
      input  wire logic                 reset,
      fir_req_if.sink                   req_bus,
      fir_rsp_if.source                 rsp_bus,
      input  wire logic                 csr_wr_en,
      input  wire logic [TAP_CNT_W-1:0] csr_wr_data
   );

   localparam int ACC_W = SAMPLE_WIDTH + COEFF_WIDTH + $clog2(MAX_TAPS + 1) + 1;

   logic [TAP_CNT_W-1:0]           tap_count_ff, tap_count_in;
   cell_ctl_type                   cell_ctl;
   logic signed [SAMPLE_WIDTH-1:0] chain_sample [MAX_TAPS+1];
   logic signed [ACC_W-1:0]        chain_psum   [MAX_TAPS+1];

   assign tap_count_in = csr_wr_en ? csr_wr_data : tap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_CNT_W'(MAX_TAPS);
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   assign chain_sample[0] = req_bus.sample_in;
   assign chain_psum[0]   = '0;

   for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
      logic active;
      logic tap_wr;

      // cell 0 always counts, so a tap count of zero acts as one
      assign active = (g == 0) || (32'(tap_count_ff) > 32'(g));
      assign tap_wr = cell_ctl.load && (32'(req_bus.tap_index) == 32'(g));

      fir_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .COEFF_WIDTH  (COEFF_WIDTH),
         .ACC_W        (ACC_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (cell_ctl.shift),
         .tap_wr      (tap_wr),
         .active      (active),
         .sample_prev (chain_sample[g]),
         .coeff       (req_bus.coeff_value),
         .psum_prev   (chain_psum[g]),
         .sample_next (chain_sample[g+1]),
         .psum_next   (chain_psum[g+1])
      );
   end

   fir_ctrl #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEFF_WIDTH  (COEFF_WIDTH),
      .ACC_W        (ACC_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_op         (req_bus.op),
      .req_ready      (req_bus.ready),
      .sum            (chain_psum[MAX_TAPS]),
      .cell_ctl       (cell_ctl),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_sample_out (rsp_bus.sample_out),
      .rsp_saturated  (rsp_bus.saturated)
   );

endmodule

`default_nettype wire

/* hdl/fir_cell.sv */
// One tap of the FIR cell row: delay stage, coefficient, product register and
// partial-sum stage handed to the next cell. Depends on fir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fir_cell
   import fir_pkg::*;
   #(
      parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
      parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF,
      parameter int ACC_W        = SAMPLE_WIDTH_DEF + COEFF_WIDTH_DEF + 7
   ) (
      input  wire logic                           clock,
      input  wire logic                           reset,
      input  wire logic                           shift,
      input  wire logic                           tap_wr,
      input  wire logic                           active,
      input  wire logic signed [SAMPLE_WIDTH-1:0] sample_prev,
      input  wire logic signed [COEFF_WIDTH-1:0]  coeff,
      input  wire logic signed [ACC_W-1:0]        psum_prev,
      output logic signed [SAMPLE_WIDTH-1:0]      sample_next,
      output logic signed [ACC_W-1:0]             psum_next
   );

   localparam int PROD_W = SAMPLE_WIDTH + COEFF_WIDTH;

   logic signed [SAMPLE_WIDTH-1:0] delay_ff, delay_in;
   logic signed [COEFF_WIDTH-1:0]  tap_ff, tap_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        psum_ff, psum_in;

   always_comb begin
      delay_in = shift ? sample_prev : delay_ff;
      tap_in   = tap_wr ? coeff : tap_ff;
      // taps past the active count contribute nothing
      prod_in  = '0;
      if (active) begin
         prod_in = PROD_W'(delay_ff) * PROD_W'(tap_ff);
      end
      psum_in  = psum_prev + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         tap_ff   <= '0;
      end else begin
         delay_ff <= delay_in;
         tap_ff   <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      psum_ff <= psum_in;
   end

   assign sample_next = delay_ff;
   assign psum_next   = psum_ff;

endmodule

`default_nettype wire

/* hdl/fir_ctrl.sv */
// Sequencer for the FIR filter: request handshake, wait for the partial sum to
// ripple through the cell row, then round, saturate and register the response.
// Depends on fir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fir_ctrl
   import fir_pkg::*;
   #(
      parameter int MAX_TAPS     = MAX_TAPS_DEF,
      parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
      parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF,
      parameter int ACC_W        = SAMPLE_WIDTH_DEF + COEFF_WIDTH_DEF + 7
   ) (
      input  wire logic                           clock,
      input  wire logic                           reset,
      input  wire logic                           req_valid,
      input  wire logic                           req_op,
      output logic                                req_ready,
      input  wire logic signed [ACC_W-1:0]        sum,
      output cell_ctl_type                        cell_ctl,
      output logic                                rsp_valid,
      input  wire logic                           rsp_ready,
      output logic signed [SAMPLE_WIDTH-1:0]      rsp_sample_out,
      output logic                                rsp_saturated
   );

   // the count covers the product register, then the partial-sum register of each cell
   localparam int DONE_CNT = MAX_TAPS + 1;
   localparam int CNT_W    = $clog2(MAX_TAPS + 2);

   localparam logic signed [ACC_W-1:0] RND_HALF =
      {{(ACC_W-COEFF_WIDTH+1){1'b0}}, 1'b1, {(COEFF_WIDTH-2){1'b0}}};
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_out_ff, sample_out_in;
   logic                           sat_ff, sat_in;

   logic                           accept;
   logic                           sum_ready;
   logic                           out_free;
   logic                           finish;
   logic signed [ACC_W-1:0]        rounded;
   logic signed [ACC_W-1:0]        scaled;

   assign accept    = req_valid && req_ready;
   assign sum_ready = (cnt_ff == CNT_W'(DONE_CNT));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_op == OP_FILTER)) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (sum_ready && out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_RUN:  finish    = sum_ready && out_free;
         default: req_ready = 1'b0;
      endcase
      cell_ctl.shift = accept && (req_op == OP_FILTER);
      cell_ctl.load  = accept && (req_op == OP_LOAD);
   end

   // round half up, drop the fraction bits, clip to the sample range
   always_comb begin
      rounded = sum + RND_HALF;
      scaled  = rounded >>> (COEFF_WIDTH - 1);
      if (scaled > SAT_HI) begin
         sat_in        = 1'b1;
         sample_out_in = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (scaled < SAT_LO) begin
         sat_in        = 1'b1;
         sample_out_in = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         sat_in        = 1'b0;
         sample_out_in = scaled[SAMPLE_WIDTH-1:0];
      end
   end

   always_comb begin
      if (state_ff == ST_IDLE) begin
         cnt_in = '0;
      end else if (sum_ready) begin
         cnt_in = cnt_ff;
      end else begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         sample_out_ff <= sample_out_in;
         sat_ff        <= sat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = sample_out_ff;
   assign rsp_saturated  = sat_ff;

endmodule

`default_nettype wire
